// ===== src/mpsi_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsi_pkg: shared types and constants of the mesh plane split indexer
// Field widths, op and result codes, and controller/datapath command types.
// ----------------------------------------------------------------------------
package mpsi_pkg;

  localparam int unsigned MaxVerts = 4096;
  localparam int unsigned IdxW     = $clog2(MaxVerts);
  localparam int unsigned CntW     = IdxW + 1;

  localparam logic [1:0] OP_VERTEX = 2'd0;
  localparam logic [1:0] OP_TRI    = 2'd1;
  localparam logic [1:0] OP_BEGIN  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_PLACED = 2'd0;
  localparam logic [1:0] KIND_COPIED = 2'd1;
  localparam logic [1:0] KIND_TRI    = 2'd2;
  localparam logic [1:0] KIND_BEGIN  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_UNLOADED = 2'd2;

  localparam logic [1:0] REG_PX  = 2'd0;
  localparam logic [1:0] REG_PY  = 2'd1;
  localparam logic [1:0] REG_PZ  = 2'd2;
  localparam logic [1:0] REG_OFF = 2'd3;

  typedef struct packed {
    logic [1:0]      op;
    logic [31:0]     pos_x;
    logic [31:0]     pos_y;
    logic [31:0]     pos_z;
    logic [IdxW-1:0] corner_a;
    logic [IdxW-1:0] corner_b;
    logic [IdxW-1:0] corner_c;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic            which_mesh;
    logic [IdxW-1:0] new_index;
    logic [IdxW-1:0] source_index;
    logic [IdxW-1:0] tri_first;
    logic [IdxW-1:0] tri_second;
    logic [IdxW-1:0] tri_third;
    logic [1:0]      status;
    logic            last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;   // latch input item
    logic       mul_start; // products into registers
    logic       vtx_commit;
    logic       rd_side;   // read side bit of one corner
    logic       rd_map;    // read majority map of one corner
    logic [1:0] rd_sel;    // corner for side/map read
    logic [1:0] fix_sel;   // corner to copy
    logic       fix_do;    // write copy into map
    logic       begin_clr;
    logic [2:0] emit;      // 0 none, else emit code
  } dp_cmd_t;

  localparam logic [2:0] EM_NONE   = 3'd0;
  localparam logic [2:0] EM_VTX    = 3'd1;
  localparam logic [2:0] EM_FULL   = 3'd2;
  localparam logic [2:0] EM_UNLD   = 3'd3;
  localparam logic [2:0] EM_COPY   = 3'd4;
  localparam logic [2:0] EM_TRI    = 3'd5;
  localparam logic [2:0] EM_BEGIN  = 3'd6;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       unloaded;
    logic       split;
    logic [2:0] need_copy; // per corner: odd side and not yet in map
    logic       out_busy;
  } dp_sts_t;

endpackage

// ===== src/mpsi_if.sv =====
// ----------------------------------------------------------------------------
// mpsi_stream_if: valid/ready channel carrying one packed item
// ----------------------------------------------------------------------------
interface mpsi_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/mpsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpsi_ctrl: sequencer of the mesh plane split indexer
// Steps each item through decode, products or side and map reads, copies and result beats.
// ----------------------------------------------------------------------------
module mpsi_ctrl import mpsi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SIDE  = 3'd3;
  localparam logic [2:0] S_MAP   = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;
  localparam logic [2:0] S_MAPRD = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] todo_q, todo_d;
  logic [1:0] cor_q, cor_d;
  logic [1:0] sel;

  always_comb begin
    sel = 2'd0;
    if (todo_q[0]) sel = 2'd0;
    else if (todo_q[1]) sel = 2'd1;
    else sel = 2'd2;
  end

  always_comb begin
    state_d = state_q;
    todo_d  = todo_q;
    cor_d   = cor_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts_i.out_busy) begin
          unique case (sts_i.op)
            OP_VERTEX: begin
              if (sts_i.full) begin
                cmd_o.emit = EM_FULL;
                state_d = S_IDLE;
              end else begin
                cmd_o.mul_start = 1'b1;
                state_d = S_MUL;
              end
            end
            OP_TRI: begin
              if (sts_i.unloaded) begin
                cmd_o.emit = EM_UNLD;
                state_d = S_IDLE;
              end else begin
                cmd_o.rd_side = 1'b1;
                cmd_o.rd_sel  = 2'd0;
                cor_d = 2'd1;
                state_d = S_SIDE;
              end
            end
            OP_BEGIN: begin
              cmd_o.begin_clr = 1'b1;
              cmd_o.emit = EM_BEGIN;
              state_d = S_IDLE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        if (!sts_i.out_busy) begin
          cmd_o.vtx_commit = 1'b1;
          cmd_o.emit = EM_VTX;
          state_d = S_IDLE;
        end
      end
      // one corner side bit per cycle
      S_SIDE: begin
        cmd_o.rd_side = 1'b1;
        cmd_o.rd_sel  = cor_q;
        if (cor_q == 2'd2) begin
          cor_d = 2'd0;
          state_d = S_MAPRD;
        end else begin
          cor_d = cor_q + 2'd1;
        end
      end
      // one corner map entry per cycle, majority known by now
      S_MAPRD: begin
        cmd_o.rd_map = 1'b1;
        cmd_o.rd_sel = cor_q;
        if (cor_q == 2'd2) begin
          cor_d = 2'd0;
          state_d = S_MAP;
        end else begin
          cor_d = cor_q + 2'd1;
        end
      end
      S_MAP: begin
        todo_d = sts_i.split ? sts_i.need_copy : 3'b000;
        state_d = S_FIX;
      end
      S_FIX: begin
        if (!sts_i.out_busy) begin
          if (todo_q == 3'b000) begin
            cmd_o.emit = EM_TRI;
            state_d = S_IDLE;
          end else begin
            cmd_o.fix_sel = sel;
            cmd_o.fix_do  = 1'b1;
            cmd_o.emit    = EM_COPY;
            todo_d[sel]   = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      todo_q  <= '0;
      cor_q   <= '0;
    end else begin
      state_q <= state_d;
      todo_q  <= todo_d;
      cor_q   <= cor_d;
    end
  end

endmodule

// ===== src/mpsi_datapath.sv =====
// ----------------------------------------------------------------------------
// mpsi_datapath: plane test, vertex maps, counters and output register
// ----------------------------------------------------------------------------
module mpsi_datapath import mpsi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  logic signed [31:0] px_q, py_q, pz_q, off_q;
  in_item_t item_q;
  logic [CntW-1:0] loaded_q, neg_q, pos_q;

  // side bits and both maps; map entry is {valid, index}
  logic            side_mem [MaxVerts];
  logic [IdxW:0]   neg_mem  [MaxVerts];
  logic [IdxW:0]   pos_mem  [MaxVerts];

  logic signed [63:0] prx_q, pry_q, prz_q;
  logic [2:0]       s_q;
  logic [IdxW:0]    m_q [3];
  logic             maj;
  logic [IdxW-1:0]  cr [3];
  logic signed [65:0] sum;
  logic             side;
  logic [IdxW-1:0]  ni;
  logic [IdxW-1:0]  rd_idx;
  logic [IdxW-1:0]  fix_idx;
  logic [IdxW-1:0]  fix_ni;

  out_item_t out_q, out_d;
  logic      ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; pz_q <= '0; off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PX:  px_q  <= cfg_data_i;
        REG_PY:  py_q  <= cfg_data_i;
        REG_PZ:  pz_q  <= cfg_data_i;
        REG_OFF: off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cr[0] = item_q.corner_a;
  assign cr[1] = item_q.corner_b;
  assign cr[2] = item_q.corner_c;
  assign maj = (s_q[0] & s_q[1]) | (s_q[0] & s_q[2]) | (s_q[1] & s_q[2]);

  // offset is shifted left 16 bits into Q32.32 alignment and sign-extended
  assign sum = 66'(prx_q) + 66'(pry_q) + 66'(prz_q) + 66'($signed({off_q, 16'h0000}));
  assign side = ~sum[65];
  assign ni = side ? pos_q[IdxW-1:0] : neg_q[IdxW-1:0];
  assign rd_idx  = cr[cmd_i.rd_sel];
  assign fix_idx = cr[cmd_i.fix_sel];
  assign fix_ni  = maj ? pos_q[IdxW-1:0] : neg_q[IdxW-1:0];

  always_comb begin
    sts_o.op = item_q.op;
    sts_o.full = (loaded_q == CntW'(MaxVerts));
    sts_o.unloaded = ({1'b0, cr[0]} >= loaded_q) || ({1'b0, cr[1]} >= loaded_q)
                  || ({1'b0, cr[2]} >= loaded_q);
    sts_o.split = (s_q != 3'b000) && (s_q != 3'b111);
    for (int i = 0; i < 3; i++) begin
      sts_o.need_copy[i] = (s_q[i] != maj) && !m_q[i][IdxW];
    end
    sts_o.out_busy = ov_q && !out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
    if (cmd_i.mul_start) begin
      prx_q <= $signed(item_q.pos_x) * px_q;
      pry_q <= $signed(item_q.pos_y) * py_q;
      prz_q <= $signed(item_q.pos_z) * pz_q;
    end
    if (cmd_i.rd_side) s_q[cmd_i.rd_sel] <= side_mem[rd_idx];
    if (cmd_i.rd_map) m_q[cmd_i.rd_sel] <= maj ? pos_mem[rd_idx] : neg_mem[rd_idx];
    if (cmd_i.vtx_commit) begin
      side_mem[loaded_q[IdxW-1:0]] <= side;
      neg_mem[loaded_q[IdxW-1:0]]  <= side ? '0 : {1'b1, ni};
      pos_mem[loaded_q[IdxW-1:0]]  <= side ? {1'b1, ni} : '0;
    end
    if (cmd_i.fix_do) begin
      if (maj) pos_mem[fix_idx] <= {1'b1, fix_ni};
      else     neg_mem[fix_idx] <= {1'b1, fix_ni};
      // keep the fetched entries current, no second map pass
      for (int i = 0; i < 3; i++) begin
        if (cr[i] == fix_idx) m_q[i] <= {1'b1, fix_ni};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0; neg_q <= '0; pos_q <= '0;
    end else if (cmd_i.begin_clr) begin
      loaded_q <= '0; neg_q <= '0; pos_q <= '0;
    end else begin
      if (cmd_i.vtx_commit) begin
        loaded_q <= loaded_q + 1'b1;
        if (side) pos_q <= pos_q + 1'b1;
        else      neg_q <= neg_q + 1'b1;
      end
      if (cmd_i.fix_do) begin
        if (maj) pos_q <= pos_q + 1'b1;
        else     neg_q <= neg_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit != EM_NONE) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_comb begin
    out_d = '0;
    out_d.last = 1'b1;
    case (cmd_i.emit)
      EM_VTX: begin
        out_d.kind = KIND_PLACED;
        out_d.which_mesh = side;
        out_d.new_index = ni;
        out_d.source_index = loaded_q[IdxW-1:0];
      end
      EM_FULL: begin
        out_d.kind = KIND_PLACED;
        out_d.status = ST_FULL;
      end
      EM_UNLD: begin
        out_d.kind = KIND_TRI;
        out_d.status = ST_UNLOADED;
      end
      EM_COPY: begin
        out_d.kind = KIND_COPIED;
        out_d.which_mesh = maj;
        out_d.new_index = fix_ni;
        out_d.source_index = fix_idx;
        out_d.last = 1'b0;
      end
      EM_TRI: begin
        out_d.kind = KIND_TRI;
        out_d.which_mesh = maj;
        out_d.tri_first = m_q[0][IdxW-1:0];
        out_d.tri_second = m_q[1][IdxW-1:0];
        out_d.tri_third = m_q[2][IdxW-1:0];
      end
      default: out_d.kind = KIND_BEGIN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EM_NONE) out_q <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/mesh_plane_split_indexer_unit.sv =====
// ----------------------------------------------------------------------------
// mesh_plane_split_indexer_unit: plane split indexer for indexed meshes
// Steps: begin/error emit in decode; vertex after products; triangle after reads, fix.
// Throughput: one item at a time; side and map reads take one corner per cycle.
//   A full output register adds its wait.
// Reset: counters and plane registers clear at once; maps need no clearing.
// ----------------------------------------------------------------------------
module mesh_plane_split_indexer_unit import mpsi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpsi_stream_if.sink   in_if,
  mpsi_stream_if.source out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item = in_if.data;
  assign out_if.data = out_item;

  // sequencer: one item in flight, one beat per emitted result
  mpsi_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mpsi_datapath u_dp (
    .clk_i, .rst_ni,
    .item_i      (in_item),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_item)
  );

endmodule
